// ===== design/vau_pkg.sv =====
// ----------------------------------------------------------------------------
// vau_pkg
// Shared types, operation codes and saturation helper for the vector unit.
// ----------------------------------------------------------------------------
`default_nettype none

package vau_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int SQRT_N        = 32;   // one root bit per stage, 64-bit radicand

    localparam logic [2:0] OP_ADD   = 3'd0;
    localparam logic [2:0] OP_SUB   = 3'd1;
    localparam logic [2:0] OP_DOT   = 3'd2;
    localparam logic [2:0] OP_CROSS = 3'd3;
    localparam logic [2:0] OP_SCALE = 3'd4;
    localparam logic [2:0] OP_LEN   = 3'd5;
    localparam logic [2:0] OP_NORM  = 3'd6;
    localparam logic [2:0] OP_EQ    = 3'd7;

    localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
    localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

    typedef struct packed {
        logic [2:0]       op;
        logic             eq;
        logic [2:0][31:0] a;
    } t_front;

    typedef struct packed {
        logic [2:0]       op;
        logic             eq;
        logic [2:0][31:0] vec;
        logic             vovf;
        logic [31:0]      dot;
        logic             dovf;
        logic [2:0][31:0] a;
    } t_side;

    // {overflow, value} of v clamped to the signed 32-bit range
    function automatic logic [32:0] f_sat66(input logic signed [65:0] v);
        logic [32:0] res;
        if (v > SAT_MAX) begin
            res = {1'b1, 32'h7fff_ffff};
        end else if (v < SAT_MIN) begin
            res = {1'b1, 32'h8000_0000};
        end else begin
            res = {1'b0, v[31:0]};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== design/vector3_arithmetic_unit_core.sv =====
// ----------------------------------------------------------------------------
// vector3_arithmetic_unit_core
// Pipelined 3-component Q-format vector unit: add, sub, dot, cross, scale,
// length, normalize and equality.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on i_in_valid / o_in_ready with the operation, vectors A and
//   B and a 16-bit integer scale. Each request yields one result on
//   o_out_valid / i_out_ready. Three lanes handle x, y and z; a merge stage
//   sums the dot product and the squared length.
//   From transfer in to result valid a request passes the front and lane
//   stages, 32 square root stages one bit each, FRAC_BITS + 1 divider
//   stages, and the output register. Throughput is one request per cycle
//   while the receiver takes results; every op goes through the same
//   pipeline so results leave in order.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and o_in_ready drops until that result is transferred.
//   Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module vector3_arithmetic_unit_core
    import vau_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [2:0]         i_req_type,
    input  wire logic signed [31:0] i_a_x,
    input  wire logic signed [31:0] i_a_y,
    input  wire logic signed [31:0] i_a_z,
    input  wire logic signed [31:0] i_b_x,
    input  wire logic signed [31:0] i_b_y,
    input  wire logic signed [31:0] i_b_z,
    input  wire logic signed [15:0] i_scale_factor,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [31:0]      o_r_x,
    output logic signed [31:0]      o_r_y,
    output logic signed [31:0]      o_r_z,
    output logic signed [31:0]      o_scalar_out,
    output logic                    o_equal_flag,
    output logic                    o_overflow_flag
);

    localparam int DIV_N  = FRAC_BITS + 1;
    localparam int SIDE_N = SQRT_N + DIV_N + 1;
    localparam int VLD_N  = SIDE_N + 3;

    logic               en;
    logic [VLD_N-1:0]   r_vld;
    logic               r_out_valid;

    logic [2:0]         r_op;
    logic signed [31:0] r_a [3];
    logic signed [31:0] r_b [3];
    logic signed [15:0] r_k;
    t_front             r_f1, r_f2;

    logic signed [31:0] l_vec  [3];
    logic               l_ovf  [3];
    logic signed [63:0] l_prod [3];

    logic signed [65:0] dot_sum, dot_sh;
    logic [32:0]        dot_sat;
    logic [63:0]        sumsq;
    logic [63:0]        r_sumsq;
    t_side              n_side;
    t_side              r_side [SIDE_N];
    logic [31:0]        root;
    logic [31:0]        r_len  [DIV_N];
    logic [31:0]        q      [3];

    t_side              sd;
    logic [31:0]        len;
    logic [31:0]        n_rv   [3];
    logic [31:0]        n_sc;
    logic               n_eq, n_ovf;
    logic [31:0]        r_rv   [3];
    logic [31:0]        r_sc;
    logic               r_eq, r_ovf;

    assign en         = !r_out_valid || i_out_ready;
    assign o_in_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_vld       <= {r_vld[VLD_N-2:0], i_in_valid};
            r_out_valid <= r_vld[VLD_N-1];
        end
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_op   <= i_req_type;
            r_a[0] <= i_a_x;
            r_a[1] <= i_a_y;
            r_a[2] <= i_a_z;
            r_b[0] <= i_b_x;
            r_b[1] <= i_b_y;
            r_b[2] <= i_b_z;
            r_k    <= i_scale_factor;
        end
    end

    // op, equality and A travel beside the lane stages
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f1.op <= r_op;
            r_f1.eq <= (r_a[0] == r_b[0]) && (r_a[1] == r_b[1]) && (r_a[2] == r_b[2]);
            r_f1.a  <= {r_a[2], r_a[1], r_a[0]};
            r_f2    <= r_f1;
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_lane
        localparam int J = (g + 1) % 3;
        localparam int K = (g + 2) % 3;
        vau_lane #(
            .FRAC_BITS(FRAC_BITS)
        ) u_lane (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_op   (r_op),
            .i_a_s  (r_a[g]),
            .i_a_j  (r_a[J]),
            .i_a_k  (r_a[K]),
            .i_b_s  (r_b[g]),
            .i_b_j  (r_b[J]),
            .i_b_k  (r_b[K]),
            .i_k    (r_k),
            .o_vec  (l_vec[g]),
            .o_ovf  (l_ovf[g]),
            .o_prod (l_prod[g])
        );
    end

    // merge: dot product and squared length
    always_comb begin
        dot_sum = {{2{l_prod[0][63]}}, l_prod[0]} + {{2{l_prod[1][63]}}, l_prod[1]}
                + {{2{l_prod[2][63]}}, l_prod[2]};
        dot_sh  = dot_sum >>> FRAC_BITS;
        dot_sat = f_sat66(dot_sh);
        sumsq   = l_prod[0] + l_prod[1] + l_prod[2];

        n_side.op   = r_f2.op;
        n_side.eq   = r_f2.eq;
        n_side.vec  = {l_vec[2], l_vec[1], l_vec[0]};
        n_side.vovf = l_ovf[0] || l_ovf[1] || l_ovf[2];
        n_side.dot  = dot_sat[31:0];
        n_side.dovf = dot_sat[32];
        n_side.a    = r_f2.a;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sumsq   <= sumsq;
            r_side[0] <= n_side;
            for (int i = 1; i < SIDE_N; i++) begin
                r_side[i] <= r_side[i-1];
            end
            r_len[0] <= root;
            for (int i = 1; i < DIV_N; i++) begin
                r_len[i] <= r_len[i-1];
            end
        end
    end

    vau_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (r_sumsq),
        .o_root (root)
    );

    for (genvar g = 0; g < 3; g++) begin : g_div
        vau_div #(
            .FRAC_BITS(FRAC_BITS)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_a   (r_side[SQRT_N].a[g]),
            .i_len (root),
            .o_q   (q[g])
        );
    end

    // final select
    always_comb begin
        sd    = r_side[SIDE_N-1];
        len   = r_len[DIV_N-1];
        n_rv  = '{default: '0};
        n_sc  = '0;
        n_eq  = 1'b0;
        n_ovf = 1'b0;
        unique case (sd.op)
            OP_ADD, OP_SUB, OP_CROSS, OP_SCALE: begin
                n_rv[0] = sd.vec[0];
                n_rv[1] = sd.vec[1];
                n_rv[2] = sd.vec[2];
                n_ovf   = sd.vovf;
            end
            OP_DOT: begin
                n_sc  = sd.dot;
                n_ovf = sd.dovf;
            end
            OP_LEN: begin
                n_sc  = len[31] ? 32'h7fff_ffff : len;
                n_ovf = len[31];
            end
            OP_NORM: begin
                // a zero vector has zero length and comes back as zero
                if (len != '0) begin
                    n_rv[0] = q[0];
                    n_rv[1] = q[1];
                    n_rv[2] = q[2];
                end
            end
            OP_EQ: n_eq = sd.eq;
            default: n_eq = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rv  <= n_rv;
            r_sc  <= n_sc;
            r_eq  <= n_eq;
            r_ovf <= n_ovf;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_r_x           = r_rv[0];
    assign o_r_y           = r_rv[1];
    assign o_r_z           = r_rv[2];
    assign o_scalar_out    = r_sc;
    assign o_equal_flag    = r_eq;
    assign o_overflow_flag = r_ovf;

endmodule

`default_nettype wire

// ===== design/vau_lane.sv =====
// ----------------------------------------------------------------------------
// vau_lane
// One component lane: two multipliers, then add/sub, cross, scale results.
// ----------------------------------------------------------------------------
`default_nettype none

module vau_lane
    import vau_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic [2:0]         i_op,
    input  wire logic signed [31:0] i_a_s,
    input  wire logic signed [31:0] i_a_j,
    input  wire logic signed [31:0] i_a_k,
    input  wire logic signed [31:0] i_b_s,
    input  wire logic signed [31:0] i_b_j,
    input  wire logic signed [31:0] i_b_k,
    input  wire logic signed [15:0] i_k,
    output logic signed [31:0]      o_vec,
    output logic                    o_ovf,
    output logic signed [63:0]      o_prod
);

    logic signed [31:0] m1_a, m1_b;
    logic signed [63:0] r_p1, r_p2;
    logic signed [32:0] r_sum;
    logic [2:0]         r_op;
    logic signed [64:0] diff;
    logic signed [64:0] diff_sh;
    logic [32:0]        sat;
    logic signed [31:0] r_vec;
    logic               r_ovf;
    logic signed [63:0] r_prod;

    always_comb begin
        m1_a = i_a_s;
        m1_b = i_b_s;
        unique case (i_op)
            OP_CROSS: begin
                m1_a = i_a_j;
                m1_b = i_b_k;
            end
            OP_SCALE: m1_b = {{16{i_k[15]}}, i_k};
            OP_LEN, OP_NORM: m1_b = i_a_s;
            default: begin
                m1_a = i_a_s;
                m1_b = i_b_s;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_op  <= i_op;
            r_p1  <= m1_a * m1_b;
            r_p2  <= i_a_k * i_b_j;
            r_sum <= (i_op == OP_SUB) ? ({i_a_s[31], i_a_s} - {i_b_s[31], i_b_s})
                                      : ({i_a_s[31], i_a_s} + {i_b_s[31], i_b_s});
        end
    end

    always_comb begin
        diff    = {r_p1[63], r_p1} - {r_p2[63], r_p2};
        diff_sh = diff >>> FRAC_BITS;
        unique case (r_op)
            OP_ADD, OP_SUB: sat = f_sat66({{33{r_sum[32]}}, r_sum});
            OP_CROSS:       sat = f_sat66({diff_sh[64], diff_sh});
            OP_SCALE:       sat = f_sat66({{2{r_p1[63]}}, r_p1});
            default:        sat = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vec  <= sat[31:0];
            r_ovf  <= sat[32];
            r_prod <= r_p1;
        end
    end

    assign o_vec  = r_vec;
    assign o_ovf  = r_ovf;
    assign o_prod = r_prod;

endmodule

`default_nettype wire

// ===== design/vau_isqrt.sv =====
// ----------------------------------------------------------------------------
// vau_isqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module vau_isqrt
    import vau_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [63:0] i_rad,
    output logic [31:0]      o_root
);

    logic [63:0] r_rad  [SQRT_N];
    logic [34:0] r_rem  [SQRT_N];
    logic [31:0] r_root [SQRT_N];

    for (genvar s = 0; s < SQRT_N; s++) begin : g_stage
        logic [63:0] rad_in;
        logic [34:0] rem_in;
        logic [31:0] root_in;
        logic [34:0] cur;
        logic [34:0] trial;
        logic        ge;

        if (s == 0) begin : g_first
            assign rad_in  = i_rad;
            assign rem_in  = '0;
            assign root_in = '0;
        end else begin : g_next
            assign rad_in  = r_rad[s-1];
            assign rem_in  = r_rem[s-1];
            assign root_in = r_root[s-1];
        end

        always_comb begin
            cur   = {rem_in[32:0], rad_in[2*(SQRT_N-1-s)+1 -: 2]};
            trial = {1'b0, root_in, 2'b01};
            ge    = (cur >= trial);
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[s]  <= rad_in;
                r_rem[s]  <= ge ? (cur - trial) : cur;
                r_root[s] <= {root_in[30:0], ge};
            end
        end
    end

    assign o_root = r_root[SQRT_N-1];

endmodule

`default_nettype wire

// ===== design/vau_div.sv =====
// ----------------------------------------------------------------------------
// vau_div
// Pipelined restoring divider for normalize: (mag << FRAC_BITS) / len, with the sign of i_a put back.
// ----------------------------------------------------------------------------
`default_nettype none

module vau_div
    import vau_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_len,
    output logic [31:0]      o_q
);

    localparam int DIV_N = FRAC_BITS + 1;

    logic [31:0]      mag;
    logic [31:0]      r_rem [DIV_N];
    logic [DIV_N-1:0] r_q   [DIV_N];
    logic [31:0]      r_d   [DIV_N];
    logic             r_neg [DIV_N];
    logic [DIV_N-1:0] q_fin;

    assign mag = i_a[31] ? (32'd0 - i_a) : i_a;

    // quotient never exceeds 2^FRAC_BITS, so start with the high bits as remainder
    for (genvar j = 0; j < DIV_N; j++) begin : g_step
        logic [31:0]      rem_in;
        logic [DIV_N-1:0] q_in;
        logic [31:0]      d_in;
        logic             neg_in;
        logic             bit_in;
        logic [32:0]      sh;
        logic [32:0]      sub;
        logic             ge;

        if (j == 0) begin : g_first
            assign rem_in = {1'b0, mag[31:1]};
            assign q_in   = '0;
            assign d_in   = i_len;
            assign neg_in = i_a[31];
            assign bit_in = mag[0];
        end else begin : g_next
            assign rem_in = r_rem[j-1];
            assign q_in   = r_q[j-1];
            assign d_in   = r_d[j-1];
            assign neg_in = r_neg[j-1];
            assign bit_in = 1'b0;
        end

        always_comb begin
            sh  = {rem_in, bit_in};
            sub = sh - {1'b0, d_in};
            ge  = (sh >= {1'b0, d_in});
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= ge ? sub[31:0] : sh[31:0];
                r_q[j]   <= {q_in[DIV_N-2:0], ge};
                r_d[j]   <= d_in;
                r_neg[j] <= neg_in;
            end
        end
    end

    assign q_fin = r_q[DIV_N-1];
    assign o_q   = r_neg[DIV_N-1] ? (32'd0 - 32'(q_fin)) : 32'(q_fin);

endmodule

`default_nettype wire

// ===== design/vau_checker.sv =====
// ----------------------------------------------------------------------------
// vau_checker
// Port-level checks for the vector unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module vau_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [31:0] o_r_x,
    input wire logic [31:0] o_r_y,
    input wire logic [31:0] o_r_z,
    input wire logic [31:0] o_scalar_out,
    input wire logic        o_equal_flag,
    input wire logic        o_overflow_flag
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_r_x)
            && $stable(o_scalar_out) && $stable(o_overflow_flag))
        else $error("result changed while stalled");

    a_stall_backs_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input taken while output stalled");

    a_eq_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_equal_flag |-> !o_overflow_flag && o_scalar_out == 32'd0
            && o_r_x == 32'd0 && o_r_y == 32'd0 && o_r_z == 32'd0)
        else $error("equal result carries other data");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("valid result right after reset");

endmodule

bind vector3_arithmetic_unit_core vau_checker u_vau_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_r_x           (o_r_x),
    .o_r_y           (o_r_y),
    .o_r_z           (o_r_z),
    .o_scalar_out    (o_scalar_out),
    .o_equal_flag    (o_equal_flag),
    .o_overflow_flag (o_overflow_flag)
);

`default_nettype wire
